// ===== hw/rtl/sem_pkg.sv =====
// shared types and constants for the sobel edge magnitude block
// no dependencies; imported by every module of the block
package sem_pkg;

  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;   // signed gradient, range -1020..1020
  localparam int SUM_W   = 22;   // gx^2 + gy^2, at most 2080800
  localparam int OCOL_W  = 10;
  localparam int OROW_W  = 12;
  localparam int CFGW_W  = 11;
  localparam int CFGH_W  = 12;
  localparam int CFGD_W  = 12;
  localparam int ROOT_W  = 16;
  localparam int FIFO_DEPTH = 4;

  // line store depth, widest row the block handles
  localparam int MAX_WIDTH = 1024;

  // configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [PIX_W-1:0] MAG_CLAMP = 8'd255;

  // one interior pixel waiting for its magnitude
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [OCOL_W-1:0]        col;
    logic [OROW_W-1:0]        row;
    logic                     last;
  } job_t;

endpackage

// ===== hw/rtl/sem_front.sv =====
// front end: pixel intake, line stores, 3x3 window and sobel gradients
// depends on sem_pkg; pushes one job_t per interior pixel into the queue
module sem_front import sem_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_pixel,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFGD_W-1:0]   cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output job_t                q_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CALC = 1'b1;

  logic                state_r, state_nxt;
  logic [CFGW_W-1:0]   width_r;
  logic [CFGH_W-1:0]   height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [OROW_W-1:0]   row_r, row_nxt;
  logic [PIX_W-1:0]    pix_r;
  logic [PIX_W-1:0]    top_r, mid_r;
  logic [PIX_W-1:0]    win_r [6];

  logic [PIX_W-1:0]    mem_top [MAX_WIDTH];
  logic [PIX_W-1:0]    mem_mid [MAX_WIDTH];

  logic [COL_W-1:0]    w_last;
  logic [OROW_W-1:0]   h_last;
  logic                accept;
  logic                interior;
  logic [9:0]          gx_pos, gx_neg, gy_pos, gy_neg;
  logic [COL_W-1:0]    col_m1;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // effective frame size, last column and last row
  always_comb begin
    if (width_r < 11'd3) begin
      w_last = COL_W'(2);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_r - 11'd1);
    end
    if (height_r < 12'd3) begin
      h_last = 12'd2;
    end else begin
      h_last = height_r - 12'd1;
    end
  end

  // line store banks: read on accept, written back in the calc cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      top_r <= mem_top[col_r];
      mid_r <= mem_mid[col_r];
      pix_r <= in_pixel;
    end
    if (state_r == F_CALC) begin
      mem_top[col_r] <= mid_r;
      mem_mid[col_r] <= pix_r;
    end
  end

  // tl=win0 ml=win1 bl=win2 tc=win3 bc=win5 tr=top mr=mid br=pixel
  always_comb begin
    gx_pos = {2'b0, top_r} + {1'b0, mid_r, 1'b0} + {2'b0, pix_r};
    gx_neg = {2'b0, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b0, win_r[2]};
    gy_pos = {2'b0, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b0, pix_r};
    gy_neg = {2'b0, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b0, top_r};
    col_m1 = col_r - COL_W'(1);
    interior = (col_r >= COL_W'(2)) && (row_r >= 12'd2);
    q_data.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    q_data.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    q_data.col  = OCOL_W'(col_m1);
    q_data.row  = row_r - 12'd1;
    q_data.last = (col_r == w_last) && (row_r == h_last);
    q_push = (state_r == F_CALC) && interior;
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_CALC;
        end
      end
      F_CALC: begin
        state_nxt = F_IDLE;
        if (col_r == w_last) begin
          col_nxt = '0;
          row_nxt = (row_r == h_last) ? '0 : row_r + 12'd1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      width_r  <= 11'd300;
      height_r <= 12'd300;
      col_r    <= '0;
      row_r    <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cfg_we) begin
      // any register write restarts the frame
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_r <= cfg_data[CFGW_W-1:0];
      end else begin
        height_r <= cfg_data[CFGH_W-1:0];
      end
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (state_r == F_CALC) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_r;
        win_r[4] <= mid_r;
        win_r[5] <= pix_r;
      end
    end
  end

endmodule

// ===== hw/rtl/sem_fifo.sv =====
// short job queue between the gradient front end and the magnitude back end
// depends on sem_pkg for job_t and FIFO_DEPTH
module sem_fifo import sem_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  job_t             slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sem_back.sv =====
// back end: squares the gradients, takes an iterative floor square root,
// clamps and holds the result until taken; depends on sem_pkg
module sem_back import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  job_t              q_head,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_magnitude,
  output logic [OCOL_W-1:0] out_center_col,
  output logic [OROW_W-1:0] out_center_row,
  output logic              out_last_of_frame
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQR  = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  job_t                    job_r;
  logic [ROOT_W-1:0]       rem_r, root_r, bit_r;
  logic [PIX_W-1:0]        mag_r;

  logic signed [SUM_W-1:0] sq_x, sq_y;
  logic [SUM_W-1:0]        sum;
  logic [ROOT_W:0]         trial;
  logic [ROOT_W-1:0]       rem_nxt, root_nxt;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    sq_x = job_r.gx * job_r.gx;
    sq_y = job_r.gy * job_r.gy;
    sum  = $unsigned(sq_x) + $unsigned(sq_y);
  end

  // one root digit per cycle
  always_comb begin
    trial = {1'b0, root_r} + {1'b0, bit_r};
    if ({1'b0, rem_r} >= trial) begin
      rem_nxt  = rem_r - trial[ROOT_W-1:0];
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      rem_nxt  = rem_r;
      root_nxt = root_r >> 1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_SQR;
      B_SQR:  state_nxt = (sum >= SUM_W'(65536)) ? B_OUT : B_ROOT;
      B_ROOT: if (bit_r == ROOT_W'(1)) state_nxt = B_OUT;
      B_OUT:  if (out_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (state_r == B_SQR) begin
      rem_r  <= sum[ROOT_W-1:0];
      root_r <= '0;
      bit_r  <= ROOT_W'(1) << (ROOT_W - 2);
      mag_r  <= MAG_CLAMP;
    end else if (state_r == B_ROOT) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_r >> 2;
      if (bit_r == ROOT_W'(1)) begin
        mag_r <= root_nxt[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid         = (state_r == B_OUT);
  assign out_magnitude     = mag_r;
  assign out_center_col    = job_r.col;
  assign out_center_row    = job_r.row;
  assign out_last_of_frame = job_r.last;

endmodule

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// top level of the sobel edge magnitude block
// depends on sem_pkg, sem_front, sem_fifo and sem_back
//
// Streams 8-bit grey pixels in raster order and returns, for each interior
// pixel, floor(sqrt(gx^2 + gy^2)) clamped to 255 with its column, row and an
// end-of-frame flag; border pixels give no result. The front end takes a
// new pixel only when idle and the queue is not full (registered read of
// the two line-store banks, then window shift and gradient), and pushes
// interior jobs into a 4-entry queue. The back end squares each job; a job
// whose sum saturates goes straight to output, any other runs the eight
// root steps of its digit-serial square root unit before output, so the
// sustained rate over a frame is set by that root unit and by out_ready.
// Writing either register restarts the frame; the line stores are not
// cleared and need no clearing pass.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_magnitude,
  output logic [OCOL_W-1:0] out_center_col,
  output logic [OROW_W-1:0] out_center_row,
  output logic              out_last_of_frame,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFGD_W-1:0] cfg_data
);

  logic q_push, q_pop, q_full, q_empty;
  job_t q_in, q_head;

  sem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  sem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sem_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_head            (q_head),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_magnitude     (out_magnitude),
    .out_center_col    (out_center_col),
    .out_center_row    (out_center_row),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
